>>> src/pit_pkg.sv
// Package for the point-in-tetrahedron test: sequencer states, face table and field constants.
package pit_pkg;

  // Width of each coordinate field on the ports.
  localparam int FIELD_W = 16;

  // Mode codes.
  localparam logic [2:0] MODE_TEST = 3'd4;

  typedef logic [1:0] vidx_t;

  // Each row lists three face vertices and then the opposite vertex.
  localparam vidx_t FACE_TAB [4][4] = '{
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd0, 2'd1, 2'd3, 2'd2},
    '{2'd0, 2'd2, 2'd3, 2'd1},
    '{2'd1, 2'd2, 2'd3, 2'd0}
  };

  localparam vidx_t LAST_FACE = 2'd3;
  localparam logic [1:0] LAST_STEP = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DIFF,
    ST_MAC,
    ST_CHECK
  } pit_state_e;

endpackage

>>> src/point_in_tetrahedron_test_core.sv
// Point-in-tetrahedron test: vertex store, shared multiply-accumulate unit and its sequencer.
//
// Words with mode 0 to 3 write that vertex of the tetrahedron and give no result. A mode 4
// word is a query: for each of the four faces the block reads the face's three vertices
// and its opposite vertex from the vertex store over its one read port, then works out two
// exact 3x3 orientation determinants, first against the opposite vertex and then against
// the query, each as a step of differences, three groups on the single shared
// multiply-accumulate unit that each fold one 2x2 minor into the determinant, and a sign
// check. A query stops at the first face that has the query strictly outside. The block
// takes no new word while a query is at work; the result sits in an output register, so
// the next word is taken while it waits. A query that ends while an earlier result still
// waits stays in its last sign check until that result is taken. Modes 5 to 7 are taken
// and ignored. Coordinates are the low COORD_BITS bits of each field, sign extended, while
// COORD_BITS is at most FIELD_W; above that the whole field is taken zero extended. A query
// that uses a vertex never written since reset gives an arbitrary answer.
module point_in_tetrahedron_test_core #(
  parameter int COORD_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [2:0]                           mode_i,
  input  logic signed [pit_pkg::FIELD_W-1:0]   coord_x_i,
  input  logic signed [pit_pkg::FIELD_W-1:0]   coord_y_i,
  input  logic signed [pit_pkg::FIELD_W-1:0]   coord_z_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 inside_res_o
);

  // Above the field width the sign bit lies beyond the port, so the value is zero extended.
  localparam int VW    = (COORD_BITS > pit_pkg::FIELD_W) ? pit_pkg::FIELD_W + 1 : COORD_BITS;
  localparam int VTX_W = 3 * VW;
  localparam int D     = VW + 1;
  localparam int T_W   = 2 * D + 1;
  localparam int P_W   = D + T_W;
  localparam int ACC_W = 3 * D + 2;

  pit_pkg::pit_state_e state_q, state_d;

  logic signed [VW-1:0] x_in, y_in, z_in;
  logic                 in_acc;
  logic                 out_load;
  logic                 out_free;

  logic [VTX_W-1:0] mem [4];
  logic [VTX_W-1:0] rd_data_q;
  pit_pkg::vidx_t   rd_addr;

  logic [VTX_W-1:0] p_q, va_q, vb_q, vc_q, vo_q;
  logic [VTX_W-1:0] tgt_vtx;
  logic [2:0]       cnt_q;
  pit_pkg::vidx_t   face_q;
  logic             tgt_q;
  logic             flip_q;
  logic [1:0]       grp_q, ph_q;

  logic signed [D-1:0] adx_q, ady_q, adz_q, bdx_q, bdy_q, bdz_q, cdx_q, cdy_q, cdz_q;
  logic signed [D-1:0] sel_x, sel_y1, sel_z1, sel_y2, sel_z2;
  logic signed [D-1:0] mul_a;
  logic signed [T_W-1:0] mul_b;
  logic signed [P_W-1:0] prod;
  logic signed [T_W-1:0] t_q;
  logic signed [ACC_W-1:0] acc_q, acc_base;

  logic acc_pos, acc_neg, face_out, mac_last;

  logic out_valid_q, inside_q;

  generate
    if (COORD_BITS > pit_pkg::FIELD_W) begin : g_zext
      assign x_in = $signed({1'b0, coord_x_i});
      assign y_in = $signed({1'b0, coord_y_i});
      assign z_in = $signed({1'b0, coord_z_i});
    end else begin : g_sext
      assign x_in = $signed(coord_x_i[VW-1:0]);
      assign y_in = $signed(coord_y_i[VW-1:0]);
      assign z_in = $signed(coord_z_i[VW-1:0]);
    end
  endgenerate

  function automatic logic signed [D-1:0] sub_ext(logic [VW-1:0] u, logic [VW-1:0] v);
    return $signed({u[VW-1], u}) - $signed({v[VW-1], v});
  endfunction

  assign in_acc   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign acc_neg  = acc_q[ACC_W-1];
  assign acc_pos  = !acc_q[ACC_W-1] && (acc_q != '0);
  // A flipped face has its positive side where the raw determinant is negative.
  assign face_out = flip_q ? acc_pos : acc_neg;
  assign mac_last = (grp_q == pit_pkg::LAST_STEP) && (ph_q == pit_pkg::LAST_STEP);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      pit_pkg::ST_IDLE: begin
        if (in_acc && (mode_i == pit_pkg::MODE_TEST)) state_d = pit_pkg::ST_READ;
      end
      pit_pkg::ST_READ: begin
        if (cnt_q == 3'd4) state_d = pit_pkg::ST_DIFF;
      end
      pit_pkg::ST_DIFF: state_d = pit_pkg::ST_MAC;
      pit_pkg::ST_MAC: begin
        if (mac_last) state_d = pit_pkg::ST_CHECK;
      end
      pit_pkg::ST_CHECK: begin
        if (!tgt_q) begin
          state_d = pit_pkg::ST_DIFF;
        end else if (face_out || (face_q == pit_pkg::LAST_FACE)) begin
          if (out_free) state_d = pit_pkg::ST_IDLE;
        end else begin
          state_d = pit_pkg::ST_READ;
        end
      end
      default: state_d = pit_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_ready_o = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      pit_pkg::ST_IDLE:  in_ready_o = 1'b1;
      pit_pkg::ST_CHECK: out_load = tgt_q && out_free &&
                                    (face_out || (face_q == pit_pkg::LAST_FACE));
      default: begin
        in_ready_o = 1'b0;
        out_load   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pit_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Vertex store with one write and one registered read port.
  assign rd_addr = pit_pkg::FACE_TAB[face_q][cnt_q[1:0]];

  always_ff @(posedge clk_i) begin
    if (in_acc && (mode_i < pit_pkg::MODE_TEST)) begin
      mem[mode_i[1:0]] <= {x_in, y_in, z_in};
    end
    rd_data_q <= mem[rd_addr];
  end

  // Control counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      face_q <= '0;
      tgt_q  <= 1'b0;
      flip_q <= 1'b0;
      grp_q  <= '0;
      ph_q   <= '0;
    end else begin
      case (state_q)
        pit_pkg::ST_IDLE: begin
          cnt_q  <= '0;
          face_q <= '0;
          tgt_q  <= 1'b0;
        end
        pit_pkg::ST_READ: cnt_q <= cnt_q + 3'd1;
        pit_pkg::ST_DIFF: begin
          grp_q <= '0;
          ph_q  <= '0;
        end
        pit_pkg::ST_MAC: begin
          if (ph_q == pit_pkg::LAST_STEP) begin
            ph_q  <= '0;
            grp_q <= grp_q + 2'd1;
          end else begin
            ph_q <= ph_q + 2'd1;
          end
        end
        pit_pkg::ST_CHECK: begin
          if (!tgt_q) begin
            flip_q <= acc_neg;
            tgt_q  <= 1'b1;
          end else if (!face_out && (face_q != pit_pkg::LAST_FACE)) begin
            face_q <= face_q + 2'd1;
            tgt_q  <= 1'b0;
            cnt_q  <= '0;
          end
        end
        default: cnt_q <= '0;
      endcase
    end
  end

  // Face vertices arrive in the cycle after their read address.
  always_ff @(posedge clk_i) begin
    if (in_acc && (mode_i == pit_pkg::MODE_TEST)) p_q <= {x_in, y_in, z_in};
    if (state_q == pit_pkg::ST_READ) begin
      case (cnt_q)
        3'd1:    va_q <= rd_data_q;
        3'd2:    vb_q <= rd_data_q;
        3'd3:    vc_q <= rd_data_q;
        3'd4:    vo_q <= rd_data_q;
        default: va_q <= va_q;
      endcase
    end
  end

  assign tgt_vtx = tgt_q ? p_q : vo_q;

  always_ff @(posedge clk_i) begin
    if (state_q == pit_pkg::ST_DIFF) begin
      adx_q <= sub_ext(va_q[3*VW-1:2*VW], tgt_vtx[3*VW-1:2*VW]);
      ady_q <= sub_ext(va_q[2*VW-1:VW],   tgt_vtx[2*VW-1:VW]);
      adz_q <= sub_ext(va_q[VW-1:0],      tgt_vtx[VW-1:0]);
      bdx_q <= sub_ext(vb_q[3*VW-1:2*VW], tgt_vtx[3*VW-1:2*VW]);
      bdy_q <= sub_ext(vb_q[2*VW-1:VW],   tgt_vtx[2*VW-1:VW]);
      bdz_q <= sub_ext(vb_q[VW-1:0],      tgt_vtx[VW-1:0]);
      cdx_q <= sub_ext(vc_q[3*VW-1:2*VW], tgt_vtx[3*VW-1:2*VW]);
      cdy_q <= sub_ext(vc_q[2*VW-1:VW],   tgt_vtx[2*VW-1:VW]);
      cdz_q <= sub_ext(vc_q[VW-1:0],      tgt_vtx[VW-1:0]);
    end
  end

  // Each group builds one 2x2 minor in two steps, then folds it into the determinant.
  always_comb begin
    case (grp_q)
      2'd0: begin
        sel_x = adx_q; sel_y1 = bdy_q; sel_z1 = bdz_q; sel_y2 = cdy_q; sel_z2 = cdz_q;
      end
      2'd1: begin
        sel_x = bdx_q; sel_y1 = cdy_q; sel_z1 = cdz_q; sel_y2 = ady_q; sel_z2 = adz_q;
      end
      default: begin
        sel_x = cdx_q; sel_y1 = ady_q; sel_z1 = adz_q; sel_y2 = bdy_q; sel_z2 = bdz_q;
      end
    endcase
    case (ph_q)
      2'd0: begin
        mul_a = sel_y1;
        mul_b = T_W'(sel_z2);
      end
      2'd1: begin
        mul_a = sel_z1;
        mul_b = T_W'(sel_y2);
      end
      default: begin
        mul_a = sel_x;
        mul_b = t_q;
      end
    endcase
  end

  assign prod     = mul_a * mul_b;
  assign acc_base = (grp_q == 2'd0) ? '0 : acc_q;

  always_ff @(posedge clk_i) begin
    if (state_q == pit_pkg::ST_MAC) begin
      case (ph_q)
        2'd0:    t_q <= prod[T_W-1:0];
        2'd1:    t_q <= t_q - prod[T_W-1:0];
        default: acc_q <= acc_base + ACC_W'(prod);
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) inside_q <= !face_out;
  end

  assign out_valid_o  = out_valid_q;
  assign inside_res_o = inside_q;

  a_rose_from_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == pit_pkg::ST_CHECK)
    else $error("result word appeared outside the sign check");

  a_query_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (mode_i == pit_pkg::MODE_TEST)) |=> (state_q == pit_pkg::ST_READ) && (cnt_q == 3'd0)
      && (face_q == '0) && !tgt_q)
    else $error("query word did not start at the first face");

  a_mac_to_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pit_pkg::ST_MAC) && mac_last |=> state_q == pit_pkg::ST_CHECK)
    else $error("determinant did not end after nine steps");

  a_opposite_then_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pit_pkg::ST_CHECK) && !tgt_q |=> (state_q == pit_pkg::ST_DIFF) && tgt_q)
    else $error("query determinant did not follow the opposite vertex");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free)
    else $error("result word overwritten while waiting");

endmodule
